@@ design/qdpl_pkg.sv @@
// ============================================================================
// qdpl_pkg
// Shared types and constants for the quadrature detent and press latch unit.
// ============================================================================
package qdpl_pkg;

    // Request opcodes.
    localparam logic OP_POLL    = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROT_A_POS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROT_B_POS   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_PORT   = 2'd3;

    // Phase reset value, invalid-state marker and port width masks.
    localparam logic [1:0]  PHASE_RESET  = 2'b11;
    localparam logic [15:0] STATE_INVALID = 16'hFFFF;
    localparam logic [15:0] NARROW_MASK   = 16'h00FF;
    localparam logic [15:0] WIDE_MASK     = 16'hFFFF;

    // Quadrature transition table, indexed by {previous phase, new phase}.
    localparam logic signed [1:0] PHASE_STEP [16] = '{
        2'sd0,  2'sd1,  -2'sd1, 2'sd0,
        -2'sd1, 2'sd0,  2'sd0,  2'sd1,
        2'sd1,  2'sd0,  2'sd0,  -2'sd1,
        2'sd0,  -2'sd1, 2'sd1,  2'sd0
    };

    // One request: a poll sample or a host consume.
    typedef struct packed {
        logic               op;
        logic [15:0]        sample;
        logic               read_ok;
        logic signed [31:0] consume_detents;
        logic [15:0]        consume_mask;
    } req_t;

    // One response: the unit state after the request.
    typedef struct packed {
        logic [15:0]        port_state;
        logic               port_state_valid;
        logic signed [31:0] detent_count;
        logic [31:0]        change_seq;
        logic [15:0]        pressed_bits;
        logic [31:0]        good_polls;
        logic [31:0]        bus_errors;
        logic               wake_host;
    } rsp_t;

endpackage

@@ design/quadrature_detent_and_press_latch_unit.sv @@
// ============================================================================
// quadrature_detent_and_press_latch_unit
// Rotary encoder detent counter with a two-sample button press latch.
// ============================================================================
//
//  Channel   Signals                         Direction  Content
//  --------  ------------------------------  ---------  ------------------------
//  req       req_valid, req_ready, req       in         poll sample or consume
//  rsp       rsp_valid, rsp_ready, rsp       out        state after each request
//  cfg       cfg_we, cfg_index, cfg_wdata    in         register writes, no wait
//
//  Every request passes an input register and then a result register
//  before its response is offered; one request per cycle is sustained
//  while responses are taken. The state update between the two registers
//  sets that rate. Reset is asynchronous and active low and needs no
//  warm-up. A stalled response holds both stages; the input register
//  frees as soon as its request moves into the result register.
//
module quadrature_detent_and_press_latch_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  qdpl_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output qdpl_pkg::rsp_t                      rsp,
    input  logic                                cfg_we,
    input  logic [qdpl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [qdpl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import qdpl_pkg::*;

    // Configuration registers.
    logic       poll_enable_reg;
    logic [3:0] rot_a_pos_reg;
    logic [3:0] rot_b_pos_reg;
    logic       wide_port_reg;

    // Pipeline registers.
    logic s1_valid_reg;
    req_t s1_item_reg;
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    // Unit state.
    logic [1:0]         prev_phase_reg,   prev_phase_next;
    logic signed [2:0]  step_acc_reg,     step_acc_next;
    logic [15:0]        last_sample_reg,  last_sample_next;
    logic               last_valid_reg,   last_valid_next;
    logic signed [31:0] detent_reg,       detent_next;
    logic [31:0]        seq_reg,          seq_next;
    logic [15:0]        sticky_reg,       sticky_next;
    logic [15:0]        low_hist_reg,     low_hist_next;
    logic [31:0]        polls_reg,        polls_next;
    logic [31:0]        errors_reg,       errors_next;

    // Datapath intermediates.
    logic               advance;
    logic               poll_go;
    logic               good_poll;
    logic [15:0]        rx;
    logic [1:0]         ab;
    logic signed [2:0]  acc_sum;
    logic               detent_up;
    logic               detent_down;
    logic               state_change;
    logic [15:0]        latch_mask;
    logic [15:0]        low_bits;
    rsp_t               rsp_next;

    // Handshake: the input stage moves on whenever the result stage can take it.
    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_enable_reg <= 1'b1;
            rot_a_pos_reg   <= 4'd0;
            rot_b_pos_reg   <= 4'd1;
            wide_port_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLL_ENABLE: poll_enable_reg <= cfg_wdata[0];
                CFG_ROT_A_POS:   rot_a_pos_reg   <= cfg_wdata;
                CFG_ROT_B_POS:   rot_b_pos_reg   <= cfg_wdata;
                CFG_WIDE_PORT:   wide_port_reg   <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_item_reg <= req;
        end
    end

    // Sample decode: port width, encoder phases and button mask.
    assign poll_go   = (s1_item_reg.op == OP_POLL) && poll_enable_reg;
    assign good_poll = poll_go && s1_item_reg.read_ok;
    assign rx        = wide_port_reg ? s1_item_reg.sample
                                     : (s1_item_reg.sample & NARROW_MASK);
    assign ab        = {rx[rot_a_pos_reg], rx[rot_b_pos_reg]};
    assign acc_sum   = step_acc_reg + 3'(PHASE_STEP[{prev_phase_reg, ab}]);
    assign detent_up   = (ab != prev_phase_reg) && (acc_sum >= 3'sd2);
    assign detent_down = (ab != prev_phase_reg) && (acc_sum <= -3'sd2);
    assign latch_mask  = (wide_port_reg ? WIDE_MASK : NARROW_MASK)
                         & ~((16'd1 << rot_a_pos_reg) | (16'd1 << rot_b_pos_reg));
    assign low_bits     = ~rx & latch_mask;
    assign state_change = !last_valid_reg || (rx != last_sample_reg);

    // Next state for the request in the input register.
    always_comb
    begin
        prev_phase_next  = prev_phase_reg;
        step_acc_next    = step_acc_reg;
        last_sample_next = last_sample_reg;
        last_valid_next  = last_valid_reg;
        detent_next      = detent_reg;
        seq_next         = seq_reg;
        sticky_next      = sticky_reg;
        low_hist_next    = low_hist_reg;
        polls_next       = polls_reg;
        errors_next      = errors_reg;

        if (s1_item_reg.op == OP_CONSUME)
        begin
            detent_next = detent_reg - s1_item_reg.consume_detents;
            sticky_next = sticky_reg & ~s1_item_reg.consume_mask;
        end
        else if (good_poll)
        begin
            polls_next = polls_reg + 32'd1;

            // Quadrature accumulation, one detent per two steps.
            if (ab != prev_phase_reg)
            begin
                prev_phase_next = ab;
                if (detent_up || detent_down)
                begin
                    step_acc_next = 3'sd0;
                end
                else
                begin
                    step_acc_next = acc_sum;
                end
            end
            if (detent_up)
            begin
                detent_next = detent_reg + 32'sd1;
            end
            else if (detent_down)
            begin
                detent_next = detent_reg - 32'sd1;
            end

            // Press latch needs two consecutive low samples.
            sticky_next   = sticky_reg | (low_bits & low_hist_reg);
            low_hist_next = low_bits;

            if (state_change)
            begin
                last_sample_next = rx;
                last_valid_next  = 1'b1;
            end
            seq_next = seq_reg + 32'(detent_up || detent_down) + 32'(state_change);
        end
        else if (poll_go)
        begin
            errors_next = errors_reg + 32'd1;
        end
    end

    // Response content, taken from the next state.
    always_comb
    begin
        rsp_next.port_state       = last_valid_next ? last_sample_next : STATE_INVALID;
        rsp_next.port_state_valid = last_valid_next;
        rsp_next.detent_count     = detent_next;
        rsp_next.change_seq       = seq_next;
        rsp_next.pressed_bits     = sticky_next;
        rsp_next.good_polls       = polls_next;
        rsp_next.bus_errors       = errors_next;
        rsp_next.wake_host        = good_poll && state_change;
    end

    // State update when the request moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_phase_reg  <= PHASE_RESET;
            step_acc_reg    <= 3'sd0;
            last_sample_reg <= 16'd0;
            last_valid_reg  <= 1'b0;
            detent_reg      <= 32'sd0;
            seq_reg         <= 32'd0;
            sticky_reg      <= 16'd0;
            low_hist_reg    <= 16'd0;
            polls_reg       <= 32'd0;
            errors_reg      <= 32'd0;
        end
        else if (advance)
        begin
            prev_phase_reg  <= prev_phase_next;
            step_acc_reg    <= step_acc_next;
            last_sample_reg <= last_sample_next;
            last_valid_reg  <= last_valid_next;
            detent_reg      <= detent_next;
            seq_reg         <= seq_next;
            sticky_reg      <= sticky_next;
            low_hist_reg    <= low_hist_next;
            polls_reg       <= polls_next;
            errors_reg      <= errors_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (!rsp_valid_reg || rsp_ready)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule
